// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes and keyword table for the source tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int POS_W      = 16;
	localparam int KW_CHARS   = 6;
	localparam int KW_IDX_W   = $clog2(KW_CHARS);
	localparam int MAX_LEN    = 255;
	localparam int NUM_KW     = 13;
	localparam int KIND_W     = 6;
	localparam int START_W    = 16;
	localparam int LEN_W      = 8;
	localparam int Q_DEPTH    = 8;
	localparam int Q_IDX_W    = $clog2(Q_DEPTH);
	localparam int Q_LVL_W    = Q_IDX_W + 1;

	// token kinds
	localparam logic [KIND_W-1:0] K_ERR    = 6'd0;
	localparam logic [KIND_W-1:0] K_IDENT  = 6'd14;
	localparam logic [KIND_W-1:0] K_NUM    = 6'd15;
	localparam logic [KIND_W-1:0] K_ASSIGN = 6'd16;
	localparam logic [KIND_W-1:0] K_EQEQ   = 6'd17;
	localparam logic [KIND_W-1:0] K_COLON  = 6'd18;
	localparam logic [KIND_W-1:0] K_DEFINE = 6'd19;
	localparam logic [KIND_W-1:0] K_GT     = 6'd20;
	localparam logic [KIND_W-1:0] K_GE     = 6'd21;
	localparam logic [KIND_W-1:0] K_LT     = 6'd22;
	localparam logic [KIND_W-1:0] K_LE     = 6'd23;
	localparam logic [KIND_W-1:0] K_SHL    = 6'd24;
	localparam logic [KIND_W-1:0] K_NE     = 6'd25;
	localparam logic [KIND_W-1:0] K_PLUS   = 6'd26;
	localparam logic [KIND_W-1:0] K_MINUS  = 6'd27;
	localparam logic [KIND_W-1:0] K_STAR   = 6'd28;
	localparam logic [KIND_W-1:0] K_SLASH  = 6'd29;
	localparam logic [KIND_W-1:0] K_LPAR   = 6'd30;
	localparam logic [KIND_W-1:0] K_RPAR   = 6'd31;
	localparam logic [KIND_W-1:0] K_LBRK   = 6'd32;
	localparam logic [KIND_W-1:0] K_RBRK   = 6'd33;
	localparam logic [KIND_W-1:0] K_LBRC   = 6'd34;
	localparam logic [KIND_W-1:0] K_RBRC   = 6'd35;
	localparam logic [KIND_W-1:0] K_COMMA  = 6'd36;
	localparam logic [KIND_W-1:0] K_SEMI   = 6'd37;
	localparam logic [KIND_W-1:0] K_HASH   = 6'd38;
	localparam logic [KIND_W-1:0] K_QUOTE  = 6'd39;
	localparam logic [KIND_W-1:0] K_END    = 6'd40;

	// keyword text, first character in the low byte, zero padded
	localparam logic [KW_CHARS*8-1:0] KW_TEXT [NUM_KW] = '{
		48'h0000_0000_6669,  // if
		48'h0000_6e65_6874,  // then
		48'h0000_6573_6c65,  // else
		48'h0000_0064_6e65,  // end
		48'h7461_6570_6572,  // repeat
		48'h006c_6974_6e75,  // until
		48'h0000_6461_6572,  // read
		48'h0065_7469_7277,  // write
		48'h0000_0074_6e69,  // int
		48'h0000_6e69_616d,  // main
		48'h0074_616f_6c66,  // float
		48'h656c_6275_6f64,  // double
		48'h6e72_7574_6572   // return
	};
	localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
		8'd2, 8'd4, 8'd4, 8'd3, 8'd6, 8'd5, 8'd4, 8'd5, 8'd3, 8'd4, 8'd5, 8'd6, 8'd6
	};

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start_pos;
		logic [LEN_W-1:0]   tok_len;
		logic               last;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_CHARS*8-1:0] text,
		input logic [LEN_W-1:0] len);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		// first match wins, so scan from the back
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (text == KW_TEXT[i] && len == KW_LEN[i]) k = KIND_W'(i + 1);
		end
		return k;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

// ===== design/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and per-byte token logic; emits up to two tokens per byte.
// ----------------------------------------------------------------------------
module stt_scan import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic [7:0]  item_char,
	output push_t       push
);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_EQ, M_COLON, M_GT, M_LT, M_BANG,
		M_SLASH, M_COMM, M_CSTAR
	} mode_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_RBRC  = 8'h7d;

	mode_t                      mode_q, mode_n;
	logic [KW_CHARS-1:0][7:0]   buf_q, buf_n;
	logic [LEN_W-1:0]           len_q, len_n;
	logic [POS_W-1:0]           start_q, start_n;
	logic [POS_W-1:0]           pos_q;

	logic                       pre_v, idle_v, do_idle, grow;
	logic [KIND_W-1:0]          pre_k, idle_k;
	logic [POS_W-1:0]           pre_s;
	logic [LEN_W-1:0]           pre_l;
	tok_t                       pre_tok, idle_tok;
	logic [7:0]                 c;

	assign c = item_char;

	always_comb begin
		mode_n  = mode_q;
		buf_n   = buf_q;
		len_n   = len_q;
		start_n = start_q;
		pre_v   = 1'b0;
		pre_k   = K_ERR;
		pre_s   = start_q;
		pre_l   = 8'd1;
		do_idle = 1'b0;
		grow    = 1'b0;
		idle_v  = 1'b0;
		idle_k  = K_ERR;

		if (item_valid) begin
			case (mode_q)
				M_IDENT: begin
					if (is_letter(c) || is_digit(c)) begin
						grow = 1'b1;
					end else begin
						pre_v   = 1'b1;
						pre_k   = kw_kind(buf_q, len_q);
						pre_l   = len_q;
						do_idle = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit(c)) begin
						grow = 1'b1;
					end else begin
						pre_v   = 1'b1;
						pre_k   = K_NUM;
						pre_l   = len_q;
						do_idle = 1'b1;
					end
				end
				M_EQ, M_COLON, M_GT, M_BANG, M_LT: begin
					pre_v = 1'b1;
					if (mode_q == M_LT && c == CH_LT) begin
						pre_k  = K_SHL;
						pre_l  = 8'd2;
						mode_n = M_IDLE;
					end else if (c == CH_EQ) begin
						pre_l  = 8'd2;
						mode_n = M_IDLE;
						case (mode_q)
							M_EQ:    pre_k = K_EQEQ;
							M_COLON: pre_k = K_DEFINE;
							M_GT:    pre_k = K_GE;
							M_LT:    pre_k = K_LE;
							M_BANG:  pre_k = K_NE;
							default: pre_k = K_ERR;
						endcase
					end else begin
						do_idle = 1'b1;
						case (mode_q)
							M_EQ:    pre_k = K_ASSIGN;
							M_COLON: pre_k = K_COLON;
							M_GT:    pre_k = K_GT;
							M_LT:    pre_k = K_LT;
							default: pre_k = K_ERR;   // lone bang
						endcase
					end
				end
				M_SLASH: begin
					if (c == CH_STAR) begin
						mode_n = M_COMM;
					end else begin
						pre_v   = 1'b1;
						pre_k   = K_SLASH;
						do_idle = 1'b1;
					end
				end
				M_COMM, M_CSTAR: begin
					if (c == CH_NUL) begin
						// unclosed comment: end token at this byte
						pre_v  = 1'b1;
						pre_k  = K_END;
						pre_s  = pos_q;
						mode_n = M_IDLE;
					end else if (c == CH_STAR) begin
						mode_n = M_CSTAR;
					end else if (c == CH_SLASH && mode_q == M_CSTAR) begin
						mode_n = M_IDLE;
					end else begin
						mode_n = M_COMM;
					end
				end
				default: do_idle = 1'b1;
			endcase

			if (grow) begin
				if (len_q < LEN_W'(KW_CHARS)) buf_n[len_q[KW_IDX_W-1:0]] = c;
				if (len_q < LEN_W'(MAX_LEN)) len_n = len_q + 8'd1;
			end

			// scan this byte from idle
			if (do_idle) begin
				mode_n = M_IDLE;
				if (is_letter(c) || is_digit(c)) begin
					buf_n    = '0;
					buf_n[0] = c;
					len_n    = 8'd1;
					start_n  = pos_q;
					mode_n   = is_letter(c) ? M_IDENT : M_NUM;
				end else if (c != CH_SP && c != CH_LF) begin
					case (c)
						CH_EQ:    begin mode_n = M_EQ;    start_n = pos_q; end
						CH_COLON: begin mode_n = M_COLON; start_n = pos_q; end
						CH_GT:    begin mode_n = M_GT;    start_n = pos_q; end
						CH_LT:    begin mode_n = M_LT;    start_n = pos_q; end
						CH_BANG:  begin mode_n = M_BANG;  start_n = pos_q; end
						CH_SLASH: begin mode_n = M_SLASH; start_n = pos_q; end
						CH_PLUS:  begin idle_v = 1'b1; idle_k = K_PLUS;  end
						CH_MINUS: begin idle_v = 1'b1; idle_k = K_MINUS; end
						CH_STAR:  begin idle_v = 1'b1; idle_k = K_STAR;  end
						CH_LPAR:  begin idle_v = 1'b1; idle_k = K_LPAR;  end
						CH_RPAR:  begin idle_v = 1'b1; idle_k = K_RPAR;  end
						CH_LBRK:  begin idle_v = 1'b1; idle_k = K_LBRK;  end
						CH_RBRK:  begin idle_v = 1'b1; idle_k = K_RBRK;  end
						CH_LBRC:  begin idle_v = 1'b1; idle_k = K_LBRC;  end
						CH_RBRC:  begin idle_v = 1'b1; idle_k = K_RBRC;  end
						CH_COMMA: begin idle_v = 1'b1; idle_k = K_COMMA; end
						CH_SEMI:  begin idle_v = 1'b1; idle_k = K_SEMI;  end
						CH_HASH:  begin idle_v = 1'b1; idle_k = K_HASH;  end
						CH_QUOTE: begin idle_v = 1'b1; idle_k = K_QUOTE; end
						CH_NUL:   begin idle_v = 1'b1; idle_k = K_END;   end
						default:  begin idle_v = 1'b1; idle_k = K_ERR;   end
					endcase
				end
			end
		end

		pre_tok  = '{kind: pre_k, start_pos: START_W'(pre_s), tok_len: pre_l,
			last: !idle_v};
		idle_tok = '{kind: idle_k, start_pos: START_W'(pos_q), tok_len: 8'd1,
			last: 1'b1};

		push.cnt  = {1'b0, pre_v} + {1'b0, idle_v};
		push.tok0 = pre_v ? pre_tok : idle_tok;
		push.tok1 = idle_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			buf_q   <= '0;
			len_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (item_valid) begin
			mode_q  <= mode_n;
			buf_q   <= buf_n;
			len_q   <= len_n;
			start_q <= start_n;
			pos_q   <= pos_q + 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |=> pos_q == POS_W'($past(pos_q) + 1'b1))
		else $error("position did not advance by one per byte");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDENT || mode_q == M_NUM) |-> len_q != '0)
		else $error("identifier or number run with zero length");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.tok1.last && !push.tok0.last))
		else $error("last flag misplaced on a two-token byte");
`endif

endmodule

// ===== design/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Token queue: takes zero, one or two tokens per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	output tok_t               out_tok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [Q_LVL_W-1:0] level
);

	tok_t               fifo_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] wr_q, rd_q;
	logic [Q_LVL_W-1:0] level_q;
	logic               pop;

	assign out_valid = level_q != '0;
	assign out_tok   = fifo_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) fifo_q[wr_q] <= push.tok0;
		if (push.cnt == 2'd2) fifo_q[Q_IDX_W'(wr_q + 1'b1)] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + Q_IDX_W'(push.cnt);
			if (pop) rd_q <= rd_q + 1'b1;
			level_q <= level_q + Q_LVL_W'(push.cnt) - Q_LVL_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= Q_LVL_W'(Q_DEPTH))
		else $error("token queue overflow");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0 && !pop) |=> $stable(level_q))
		else $error("queue level moved without push or pop");
`endif

endmodule

// ===== design/source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one source byte per beat in tdata[7:0]; byte 0 ends the
//   input and yields an end token, after which scanning restarts from idle.
//   m_axis carries one token per beat: kind in tuser, start position and
//   length in tdata. tlast marks the final token caused by one input byte.
//   Path: an accepted byte is held in the input register; the tokens that
//   it completes are then written into the token queue, from which they are
//   presented on m_axis one per beat.
//   Throughput: one byte per cycle while s_axis_tready is high. A byte that
//   closes a lookahead token and also yields its own token produces two
//   beats, so the output side sets the pace when such bytes are dense.
//   Stall: tokens wait in an 8-entry queue; s_axis_tready drops when the
//   queue plus the byte in flight could not absorb two more tokens.
//   Reset: scanner returns to idle, position counter to 0, queue empties.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] start_pos, [23:16] tok_len
	output logic [7:0]  m_axis_tuser,   // [5:0] kind
	output logic        m_axis_tlast
);

	logic               v_s1;
	logic [7:0]         char_s1;
	push_t              push;
	tok_t               out_tok;
	logic [Q_LVL_W-1:0] level;
	logic [Q_LVL_W:0]   committed;

	// room for two tokens from the byte in flight and two from a new one
	assign committed     = {1'b0, level} + (v_s1 ? (Q_LVL_W+1)'(2) : '0);
	assign s_axis_tready = committed <= (Q_LVL_W+1)'(Q_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) char_s1 <= s_axis_tdata;
	end

	stt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s1),
		.item_char  (char_s1),
		.push       (push)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_tok   (out_tok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.level     (level)
	);

	assign m_axis_tdata = {out_tok.tok_len, out_tok.start_pos};
	assign m_axis_tuser = {2'b00, out_tok.kind};
	assign m_axis_tlast = out_tok.last;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source text tokenizer. Source bytes stream in
// through s_axis. A token predictor follows the scanner state and lines up
// the tokens each byte completes, and every m_axis beat is compared with them.
// ----------------------------------------------------------------------------
module tb_top import stt_pkg::*; ();

	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_PRINTS  = 200;

	typedef enum logic [3:0] {
		S_IDLE, S_IDENT, S_NUM, S_EQ, S_COLON, S_GT, S_LT, S_BANG, S_SLASH, S_COMM, S_CSTAR
	} scan_e;

	class token_scoreboard;
		scan_e                 mode;
		logic [KW_CHARS*8-1:0] head;
		logic [LEN_W-1:0]      run_len;
		logic [START_W-1:0]    run_start;
		logic [START_W-1:0]    pos;
		tok_t                  due_tokens[$];
		tok_t                  step_tokens[$];
		int                    errors;

		function new();
			mode      = S_IDLE;
			head      = '0;
			run_len   = '0;
			run_start = '0;
			pos       = '0;
			errors    = 0;
		endfunction

		function int pending();
			return due_tokens.size();
		endfunction

		function logic alpha(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function logic numeral(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void push_tok(logic [KIND_W-1:0] k, logic [START_W-1:0] s,
			logic [LEN_W-1:0] l);
			tok_t t;
			t.kind      = k;
			t.start_pos = s;
			t.tok_len   = l;
			t.last      = 1'b0;
			step_tokens.push_back(t);
		endfunction

		function void add_char(logic [7:0] c);
			if (run_len < KW_CHARS) head[int'(run_len) * 8 +: 8] = c;
			if (run_len < MAX_LEN) run_len++;
		endfunction

		function logic [KIND_W-1:0] word_kind();
			for (int i = 0; i < NUM_KW; i++) begin
				if (KW_LEN[i] <= KW_CHARS && run_len == KW_LEN[i] && head == KW_TEXT[i])
					return KIND_W'(i + 1);
			end
			return K_IDENT;
		endfunction

		function void from_idle(logic [7:0] c);
			logic [KIND_W-1:0] k;
			k    = K_ERR;
			mode = S_IDLE;
			if (c == " " || c == 8'h0a) return;
			if (alpha(c) || numeral(c)) begin
				head      = '0;
				run_len   = '0;
				run_start = pos;
				add_char(c);
				mode = alpha(c) ? S_IDENT : S_NUM;
				return;
			end
			case (c)
				"=":     mode = S_EQ;
				":":     mode = S_COLON;
				">":     mode = S_GT;
				"<":     mode = S_LT;
				"!":     mode = S_BANG;
				"/":     mode = S_SLASH;
				"+":     k = K_PLUS;
				"-":     k = K_MINUS;
				"*":     k = K_STAR;
				"(":     k = K_LPAR;
				")":     k = K_RPAR;
				"[":     k = K_LBRK;
				"]":     k = K_RBRK;
				"{":     k = K_LBRC;
				"}":     k = K_RBRC;
				",":     k = K_COMMA;
				";":     k = K_SEMI;
				"#":     k = K_HASH;
				8'h22:   k = K_QUOTE;
				8'h00:   k = K_END;
				default: k = K_ERR;
			endcase
			if (mode != S_IDLE) run_start = pos;
			else push_tok(k, pos, 8'd1);
		endfunction

		function void pair_or_single(logic [7:0] c, logic [7:0] second,
			logic [KIND_W-1:0] k2, logic [KIND_W-1:0] k1);
			if (c == second) begin
				push_tok(k2, run_start, 8'd2);
				mode = S_IDLE;
			end else begin
				push_tok(k1, run_start, 8'd1);
				from_idle(c);
			end
		endfunction

		// advance the scanner by one accepted byte and queue what it completes
		function void note_char(logic [7:0] c);
			tok_t t;
			step_tokens.delete();
			case (mode)
				S_IDENT: begin
					if (alpha(c) || numeral(c)) add_char(c);
					else begin
						push_tok(word_kind(), run_start, run_len);
						from_idle(c);
					end
				end
				S_NUM: begin
					if (numeral(c)) add_char(c);
					else begin
						push_tok(K_NUM, run_start, run_len);
						from_idle(c);
					end
				end
				S_EQ:    pair_or_single(c, "=", K_EQEQ, K_ASSIGN);
				S_COLON: pair_or_single(c, "=", K_DEFINE, K_COLON);
				S_GT:    pair_or_single(c, "=", K_GE, K_GT);
				S_BANG:  pair_or_single(c, "=", K_NE, K_ERR);
				S_LT: begin
					if (c == "<") begin
						push_tok(K_SHL, run_start, 8'd2);
						mode = S_IDLE;
					end else pair_or_single(c, "=", K_LE, K_LT);
				end
				S_SLASH: begin
					if (c == "*") mode = S_COMM;
					else begin
						push_tok(K_SLASH, run_start, 8'd1);
						from_idle(c);
					end
				end
				S_COMM, S_CSTAR: begin
					if (c == 8'h00) begin
						push_tok(K_END, pos, 8'd1);
						mode = S_IDLE;
					end else if (c == "*") mode = S_CSTAR;
					else if (c == "/" && mode == S_CSTAR) mode = S_IDLE;
					else mode = S_COMM;
				end
				default: from_idle(c);
			endcase
			for (int i = 0; i < step_tokens.size(); i++) begin
				t      = step_tokens[i];
				t.last = (i == step_tokens.size() - 1);
				due_tokens.push_back(t);
			end
			pos++;
		endfunction

		task report(string what);
			if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_token(tok_t got);
			tok_t want;
			if (due_tokens.size() == 0) begin
				report($sformatf("unexpected token kind %0d at %0d", got.kind, got.start_pos));
				return;
			end
			want = due_tokens.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind %0d, want %0d (token at %0d)",
					got.kind, want.kind, want.start_pos));
			if (got.start_pos != want.start_pos)
				report($sformatf("start_pos %0d, want %0d", got.start_pos, want.start_pos));
			if (got.tok_len != want.tok_len)
				report($sformatf("tok_len %0d, want %0d (token at %0d)",
					got.tok_len, want.tok_len, want.start_pos));
			if (got.last != want.last)
				report($sformatf("tlast %0b, want %0b (token at %0d)",
					got.last, want.last, want.start_pos));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] char_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [15:0] start_pos, [23:16] tok_len
	logic [7:0]  m_axis_tuser;   // [5:0] kind
	logic        m_axis_tlast;

	token_scoreboard tokens = new();
	tok_t            beat_tok;
	int unsigned     bytes_sent = 0;
	int              tx_idle_pct = 0;
	int              rx_idle_pct = 0;
	int              rx_hold = 0;
	int              quiet = 0;

	string op_text [24] = '{"=", "==", ":", ":=", ">", ">=", "<", "<=", "<<", "!=",
		"+", "-", "*", "/", "(", ")", "[", "]", "{", "}", ",", ";", "#", "\""};

	source_text_tokenizer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) tokens.note_char(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				beat_tok.kind      = m_axis_tuser[5:0];
				beat_tok.start_pos = m_axis_tdata[15:0];
				beat_tok.tok_len   = m_axis_tdata[23:16];
				beat_tok.last      = m_axis_tlast;
				tokens.check_token(beat_tok);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// output side: random backpressure, or a long hold when one is requested
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready = 1'b0;
				rx_hold--;
			end else begin
				m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
		return rand_letter();
	endfunction

	task automatic send_char(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = c;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// hold the input until every queued token has come out
	task automatic wait_for_tokens();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (tokens.pending() != 0) @(posedge clk);
	endtask

	task automatic send_token();
		int         r;
		int         n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			// keyword, now and then with a flipped case or a tail
			n = $urandom_range(0, NUM_KW - 1);
			for (int j = 0; j < KW_LEN[n]; j++) begin
				b = KW_TEXT[n][8 * j +: 8];
				if ($urandom_range(0, 19) == 0) b = b ^ 8'h20;
				send_char(b);
			end
			if ($urandom_range(0, 4) == 0) send_char(rand_alnum());
		end else if (r < 30) begin
			n = $urandom_range(1, 9);
			send_char(rand_letter());
			for (int j = 1; j < n; j++) send_char(rand_alnum());
		end else if (r < 45) begin
			n = $urandom_range(1, 6);
			for (int j = 0; j < n; j++) send_char(8'("0" + $urandom_range(0, 9)));
		end else if (r < 70) begin
			send_text(op_text[$urandom_range(0, 23)]);
		end else if (r < 77) begin
			send_text("/*");
			n = $urandom_range(0, 8);
			for (int j = 0; j < n; j++) begin
				send_char(8'($urandom_range(1, 255)));
				if ($urandom_range(0, 3) == 0) send_char("*");
			end
			send_text("*/");
		end else if (r < 82) begin
			send_char(8'h00);
		end else if (r < 90) begin
			case ($urandom_range(0, 2))
				0: send_char("!");
				1: send_char("/");
				default: begin
					send_text("/*");
					n = $urandom_range(0, 4);
					for (int j = 0; j < n; j++) send_char(rand_alnum());
					send_char(8'h00);
				end
			endcase
		end else begin
			n = $urandom_range(1, 3);
			for (int j = 0; j < n; j++) send_char(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 4))
			0: send_char(" ");
			1: send_char(8'h0a);
			default: ;
		endcase
	endtask

	task automatic send_tokens(input int count);
		int unsigned stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) send_token();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 9;
		rx_idle_pct = 78;
		// operators in every pairing, lone bang, comment with a star run, stray slash
		send_text("if x9:=12!=!<<<=<>=>==:/*c**//a");
		send_char(8'hff);
		send_char(8'h09);
		send_char(8'h00);
		send_text("/*q");
		send_char(8'h00);
		wait_for_tokens();

		// stall the output long enough to back the block up into its input
		rx_hold = 150;
		send_tokens(130);
		wait_for_tokens();

		tx_idle_pct = 78;
		rx_idle_pct = 9;
		send_tokens(130);
		wait_for_tokens();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// lengths past saturation
		send_char(rand_letter());
		repeat (259) send_char(rand_alnum());
		send_char(" ");
		repeat (260) send_char(8'("0" + $urandom_range(0, 9)));
		send_char(";");
		send_tokens(150);
		send_text("abcdefgh<=7 ");
		send_char(8'h00);
		wait_for_tokens();

		repeat (20) @(posedge clk);
		if (tokens.pending() != 0) tokens.report("tokens never arrived");
		if (tokens.errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
